[rtl/core/java_lcg_random_generator_core_macros.svh]
// ============================================================================
// java_lcg_random_generator_core_macros.svh
// Assertion macros for the LCG random generator core, empty for synthesis.
// ============================================================================
`ifndef JAVA_LCG_RANDOM_GENERATOR_CORE_MACROS_SVH
`define JAVA_LCG_RANDOM_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define JLCG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jlcg assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define JLCG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jlcg assertion failed");
`else
`define JLCG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define JLCG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/jlcg_pkg.sv]
// ============================================================================
// jlcg_pkg
// Types and constants shared by the LCG random generator core.
// ============================================================================
package jlcg_pkg;

    localparam int STATE_BITS    = 48;
    localparam int DIGIT_BITS    = 16;
    localparam int MOD_BITS      = 31;
    localparam int WORD_BITS     = 32;
    localparam int VALUE_BITS    = 64;
    localparam int MAX_DRAWS     = 4096;
    localparam int DRAW_CNT_BITS = $clog2(MAX_DRAWS + 1);
    localparam int CFG_IDX_BITS  = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_MULTIPLIER = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ADDEND     = 8'd1;

    localparam logic [STATE_BITS-1:0] MULTIPLIER_RESET = 48'd25214903917;
    localparam logic [STATE_BITS-1:0] ADDEND_RESET     = 48'd11;

    typedef enum logic [2:0] {
        CMD_SEED     = 3'd0,
        CMD_BITS     = 3'd1,
        CMD_INT      = 3'd2,
        CMD_LONG     = 3'd3,
        CMD_BOUNDED  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_POW,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

endpackage

[rtl/core/jlcg_mul_unit.sv]
// ============================================================================
// jlcg_mul_unit
// Iterative seed * multiplier + addend mod 2^48, one 16-bit digit per cycle.
// ============================================================================
module jlcg_mul_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [jlcg_pkg::STATE_BITS-1:0]   i_seed,
    input  logic [jlcg_pkg::STATE_BITS-1:0]   i_multiplier,
    input  logic [jlcg_pkg::STATE_BITS-1:0]   i_addend,
    output logic                              o_done,
    output logic [jlcg_pkg::STATE_BITS-1:0]   o_result
);

    localparam int SB = jlcg_pkg::STATE_BITS;
    localparam int DB = jlcg_pkg::DIGIT_BITS;

    logic          r_busy;
    logic          r_done;
    logic [1:0]    r_step;
    logic [SB-1:0] r_seed;
    logic [SB-1:0] r_acc;
    logic [SB-1:0] r_prod;
    logic [DB-1:0] w_digit;
    logic [SB+DB-1:0] w_pp;
    logic [SB-1:0] w_addin;

    always_comb begin
        unique case (r_step)
            2'd0:    w_digit = r_seed[DB-1:0];
            2'd1:    w_digit = r_seed[2*DB-1:DB];
            2'd2:    w_digit = r_seed[3*DB-1:2*DB];
            default: w_digit = '0;
        endcase
    end

    assign w_pp = {{SB{1'b0}}, w_digit} * {{DB{1'b0}}, i_multiplier};

    // align the previous partial product with its digit
    always_comb begin
        unique case (r_step)
            2'd1:    w_addin = r_prod;
            2'd2:    w_addin = r_prod << DB;
            2'd3:    w_addin = r_prod << (2 * DB);
            default: w_addin = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
            r_seed <= i_seed;
            r_acc  <= i_addend;
        end else if (r_busy) begin
            r_prod <= w_pp[SB-1:0];
            r_acc  <= r_acc + w_addin;
            r_step <= r_step + 2'd1;
            if (r_step == 2'd3) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

[rtl/core/jlcg_mod_unit.sv]
// ============================================================================
// jlcg_mod_unit
// Restoring remainder of two 31-bit operands, one quotient bit per cycle.
// ============================================================================
module jlcg_mod_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [jlcg_pkg::MOD_BITS-1:0]   i_dividend,
    input  logic [jlcg_pkg::MOD_BITS-1:0]   i_divisor,
    output logic                            o_done,
    output logic [jlcg_pkg::MOD_BITS-1:0]   o_rem
);

    localparam int MB = jlcg_pkg::MOD_BITS;
    localparam int CB = $clog2(MB);
    localparam logic [CB-1:0] LAST_STEP = CB'(MB - 1);

    logic          r_busy;
    logic          r_done;
    logic [CB-1:0] r_cnt;
    logic [MB-1:0] r_rem;
    logic [MB-1:0] r_dvd;
    logic [MB-1:0] r_dsr;
    logic [MB:0]   w_trial;
    logic [MB:0]   w_diff;

    assign w_trial = {r_rem, r_dvd[MB-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_dvd  <= i_dividend;
            r_dsr  <= i_divisor;
        end else if (r_busy) begin
            // keep the difference when it does not borrow
            r_rem <= w_diff[MB] ? w_trial[MB-1:0] : w_diff[MB-1:0];
            r_dvd <= r_dvd << 1;
            r_cnt <= r_cnt + CB'(1);
            if (r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[rtl/core/java_lcg_random_generator_core.sv]
// Seed, unknown command or bad bound go straight to the result; a draw runs in the
// shared 16-bit-digit multiplier, once for int or bits and twice for long; a power of
// two bound adds a multiply, any other bound a bit-serial remainder after the draw.
// One item at a time: input ready again in the cycle after the result loads; each
// rejection redraws and repeats the remainder, and a held output stalls the core.
// Reset: synchronous, active low; seed clears to zero, multiplier and addend to their default values.
// ============================================================================
// java_lcg_random_generator_core
// 48-bit linear congruential generator with seed, bits, int, long and bounded commands.
// ============================================================================
`include "java_lcg_random_generator_core_macros.svh"

module java_lcg_random_generator_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input stream
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // tdata: [63:0] seed_value, [69:64] bits_wanted, [101:70] bound, [103:102] zero
    input  logic [103:0]   s_axis_tdata,
    // tuser: [2:0] cmd
    input  logic [2:0]     s_axis_tuser,
    // output stream
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // tdata: [63:0] value
    output logic [63:0]    m_axis_tdata,
    // tuser: [0] bad_bound
    output logic           m_axis_tuser,
    // configuration write channel
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [jlcg_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [jlcg_pkg::STATE_BITS-1:0]   i_cfg_data
);

    localparam int SB = jlcg_pkg::STATE_BITS;
    localparam int MB = jlcg_pkg::MOD_BITS;
    localparam int WB = jlcg_pkg::WORD_BITS;
    localparam int VB = jlcg_pkg::VALUE_BITS;
    localparam int NB = jlcg_pkg::DRAW_CNT_BITS;
    localparam logic [NB-1:0] DRAW_LIMIT = NB'(jlcg_pkg::MAX_DRAWS);

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    jlcg_pkg::t_state r_state, n_state;
    jlcg_pkg::t_cmd   r_cmd;

    logic [SB-1:0] r_mult;
    logic [SB-1:0] r_add;
    logic [SB-1:0] r_seed;
    logic [5:0]    r_bits;
    logic [WB-1:0] r_bound;
    logic [MB-1:0] r_u;
    logic [WB-1:0] r_hi;
    logic          r_phase;
    logic [NB-1:0] r_draws;
    logic [VB-1:0] r_val;
    logic          r_bad;
    logic          r_out_valid;
    logic [VB-1:0] r_out_data;
    logic          r_out_bad;

    // ---------------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------------
    logic             w_in_fire;
    jlcg_pkg::t_cmd   w_in_cmd;
    logic [WB-1:0]    w_in_bound;
    logic             w_in_bad;

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_in_cmd   = jlcg_pkg::t_cmd'(s_axis_tuser);
    assign w_in_bound = s_axis_tdata[101:70];
    assign w_in_bad   = (w_in_bound == '0) || w_in_bound[WB-1];

    // ---------------------------------------------------------------------
    // Shared arithmetic units
    // ---------------------------------------------------------------------
    logic          w_mul_start;
    logic          w_mul_done;
    logic [SB-1:0] w_mul_res;
    logic          w_div_start;
    logic          w_div_done;
    logic [MB-1:0] w_rem;

    jlcg_mul_unit u_mul (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_mul_start),
        .i_seed       (r_seed),
        .i_multiplier (r_mult),
        .i_addend     (r_add),
        .o_done       (w_mul_done),
        .o_result     (w_mul_res)
    );

    jlcg_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_u),
        .i_divisor  (r_bound[MB-1:0]),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // ---------------------------------------------------------------------
    // Draw results and checks
    // ---------------------------------------------------------------------
    logic [WB-1:0]   w_top;
    logic [5:0]      w_bits_eff;
    logic [WB-1:0]   w_bits_word;
    logic            w_pow2;
    logic [2*MB-1:0] w_pow_prod;
    logic [WB-1:0]   w_chk;
    logic            w_mod_finish;

    assign w_top      = w_mul_res[SB-1:SB-WB];
    // clamp to 32 bits, zero bits returns zero
    assign w_bits_eff = (r_bits > 6'd32) ? 6'd32 : r_bits;
    assign w_bits_word = (w_bits_eff == 6'd0) ? '0 : (w_top >> (6'd32 - w_bits_eff));

    assign w_pow2     = ((r_bound & (r_bound - 32'd1)) == '0);
    assign w_pow_prod = {{MB{1'b0}}, r_bound[MB-1:0]} * {{MB{1'b0}}, r_u};

    // wrapped 32-bit rejection check: u - r + (bound - 1)
    assign w_chk        = {1'b0, r_u} - {1'b0, w_rem} + r_bound - 32'd1;
    assign w_mod_finish = !w_chk[WB-1] || (r_draws >= DRAW_LIMIT);

    // ---------------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jlcg_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    unique case (w_in_cmd)
                        jlcg_pkg::CMD_BITS,
                        jlcg_pkg::CMD_INT,
                        jlcg_pkg::CMD_LONG:    n_state = jlcg_pkg::ST_MUL_GO;
                        jlcg_pkg::CMD_BOUNDED: n_state = w_in_bad ? jlcg_pkg::ST_DONE
                                                                  : jlcg_pkg::ST_MUL_GO;
                        default:               n_state = jlcg_pkg::ST_DONE;
                    endcase
                end
            end
            jlcg_pkg::ST_MUL_GO:  n_state = jlcg_pkg::ST_MUL_WAIT;
            jlcg_pkg::ST_MUL_WAIT: begin
                if (w_mul_done) begin
                    unique case (r_cmd)
                        jlcg_pkg::CMD_LONG:    n_state = r_phase ? jlcg_pkg::ST_DONE
                                                                 : jlcg_pkg::ST_MUL_GO;
                        jlcg_pkg::CMD_BOUNDED: n_state = w_pow2 ? jlcg_pkg::ST_POW
                                                                : jlcg_pkg::ST_DIV_GO;
                        default:               n_state = jlcg_pkg::ST_DONE;
                    endcase
                end
            end
            jlcg_pkg::ST_POW:     n_state = jlcg_pkg::ST_DONE;
            jlcg_pkg::ST_DIV_GO:  n_state = jlcg_pkg::ST_DIV_WAIT;
            jlcg_pkg::ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = w_mod_finish ? jlcg_pkg::ST_DONE : jlcg_pkg::ST_MUL_GO;
                end
            end
            jlcg_pkg::ST_DONE: begin
                // wait until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_state = jlcg_pkg::ST_IDLE;
                end
            end
            default:              n_state = jlcg_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------------
    always_comb begin
        s_axis_tready = (r_state == jlcg_pkg::ST_IDLE);
        w_mul_start   = (r_state == jlcg_pkg::ST_MUL_GO);
        w_div_start   = (r_state == jlcg_pkg::ST_DIV_GO);
    end

    // ---------------------------------------------------------------------
    // State, configuration and datapath registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jlcg_pkg::ST_IDLE;
            r_mult  <= jlcg_pkg::MULTIPLIER_RESET;
            r_add   <= jlcg_pkg::ADDEND_RESET;
            r_seed  <= '0;
        end else begin
            r_state <= n_state;

            // drop writes beyond the register list
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == jlcg_pkg::REG_MULTIPLIER) begin
                    r_mult <= i_cfg_data;
                end else if (i_cfg_index == jlcg_pkg::REG_ADDEND) begin
                    r_add <= i_cfg_data;
                end
            end

            unique case (r_state)
                jlcg_pkg::ST_IDLE: begin
                    if (w_in_fire) begin
                        r_cmd   <= w_in_cmd;
                        r_bits  <= s_axis_tdata[69:64];
                        r_bound <= w_in_bound;
                        r_phase <= 1'b0;
                        r_draws <= NB'(1);
                        r_val   <= '0;
                        r_bad   <= (w_in_cmd == jlcg_pkg::CMD_BOUNDED) && w_in_bad;
                        if (w_in_cmd == jlcg_pkg::CMD_SEED) begin
                            r_seed <= s_axis_tdata[SB-1:0] ^ r_mult;
                        end
                    end
                end
                jlcg_pkg::ST_MUL_WAIT: begin
                    if (w_mul_done) begin
                        // advance the seed and keep the top 31 bits for bounded draws
                        r_seed <= w_mul_res;
                        r_u    <= w_mul_res[SB-1:SB-MB];
                        unique case (r_cmd)
                            jlcg_pkg::CMD_BITS: begin
                                r_val <= {{(VB-WB){w_bits_word[WB-1]}}, w_bits_word};
                            end
                            jlcg_pkg::CMD_INT: begin
                                r_val <= {{(VB-WB){w_top[WB-1]}}, w_top};
                            end
                            jlcg_pkg::CMD_LONG: begin
                                if (!r_phase) begin
                                    r_hi    <= w_top;
                                    r_phase <= 1'b1;
                                end else begin
                                    r_val <= {r_hi, {WB{1'b0}}}
                                           + {{(VB-WB){w_top[WB-1]}}, w_top};
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                jlcg_pkg::ST_POW: begin
                    r_val <= {{(VB-MB){1'b0}}, w_pow_prod[2*MB-1:MB]};
                end
                jlcg_pkg::ST_DIV_WAIT: begin
                    if (w_div_done) begin
                        if (w_mod_finish) begin
                            r_val <= {{(VB-MB){1'b0}}, w_rem};
                        end else begin
                            r_draws <= r_draws + NB'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Output register: load a finished result, hold it until the transfer
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == jlcg_pkg::ST_DONE) && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
            r_out_data  <= r_val;
            r_out_bad   <= r_bad;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_bad;
    assign o_cfg_ready   = 1'b1;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `JLCG_ASSERT_IMP(a_bad_is_zero, i_clk, i_rst_n,
                     m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    `JLCG_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_in_fire, !s_axis_tready)
    `JLCG_ASSERT_IMP(a_mul_done_state, i_clk, i_rst_n,
                     w_mul_done, r_state == jlcg_pkg::ST_MUL_WAIT)
    `JLCG_ASSERT_IMP(a_div_done_state, i_clk, i_rst_n,
                     w_div_done, r_state == jlcg_pkg::ST_DIV_WAIT)

endmodule
